>>> rtl/assert_macros.svh
// assertion helpers for the matvec checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge outside reset
`define ASSERT_IMP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen on an edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/ssmv_pkg.sv
// ----------------------------------------------------------------------------
// ssmv_pkg
// shared types and constants of the symmetric sparse matvec block
// ----------------------------------------------------------------------------
package ssmv_pkg;
   localparam int MaxDim = 1024;
   localparam int Vectors = 4;
   localparam int RowW = $clog2(MaxDim);
   localparam int VecW = (Vectors > 1) ? $clog2(Vectors) : 1;
   localparam int AddrW = VecW + RowW;
   localparam int Depth = Vectors * MaxDim;
   localparam int XW = 32;
   localparam int AccW = 48;
   localparam int YW = AccW + 1;

   localparam logic [1:0] REQ_LOAD = 2'd0;
   localparam logic [1:0] REQ_ENTRY = 2'd1;
   localparam logic [1:0] REQ_READ = 2'd2;

   localparam logic [0:0] CSR_DIMENSION = 1'd0;
   localparam logic [0:0] CSR_NUM_VECTORS = 1'd1;

   localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
   localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

   typedef struct packed {
      logic [1:0] req_type;
      logic [RowW-1:0] row_index;
      logic [RowW-1:0] col_index;
      logic [1:0] vector_select;
      logic signed [XW-1:0] value;
   } req_type_type;

   typedef struct packed {
      logic status;
      logic signed [AccW-1:0] y_value;
      logic saturated;
   } rsp_type;
endpackage

>>> rtl/ssmv_ram.sv
// ----------------------------------------------------------------------------
// ssmv_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module ssmv_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   // registered read, a write returns the old word
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

>>> rtl/ssmv_mac.sv
// ----------------------------------------------------------------------------
// ssmv_mac
// q16.16 product register and round half up; accumulate lies in the caller
// ----------------------------------------------------------------------------
module ssmv_mac (
   input  logic                            clock,
   input  logic signed [ssmv_pkg::XW-1:0]  a,
   input  logic signed [ssmv_pkg::XW-1:0]  b,
   output logic signed [ssmv_pkg::AccW:0]  prod_rnd
);
   import ssmv_pkg::*;
   logic signed [2*XW-1:0] prod_ff, prod_in;

   // product register
   assign prod_in = a * b;
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // round half up: floor((p + 2^15) / 2^16), fits 49 bits
   logic signed [2*XW:0] t;
   assign t = {prod_ff[2*XW-1], prod_ff} + (2*XW+1)'(32768);
   assign prod_rnd = t[AccW+16:16];
endmodule

>>> rtl/symmetric_sparse_matvec.sv
// ----------------------------------------------------------------------------
// symmetric_sparse_matvec
// symmetric coo sparse matrix times up to four vectors, q16.16 in, q32.16 out
// ----------------------------------------------------------------------------
// channel  dir  handshake        payload
// req      in   tvalid/tready    tdata: row, col, vsel, value; tuser: req_type
// rsp      out  tvalid/tready    tdata: y_value, saturated; tuser: status
// csr      in   we               index, data
// rsp word follows ST_RESP, entered at once if ignored; a load first passes ST_XRD,
// a read ST_XRD and ST_XWAIT, an entry ST_XRD to ST_ACC per y update: two per
// active vector off the diagonal, one on it, each a read-modify-write through one y
// ram port and one multiplier. after reset the y ram is zeroed; no word accepted.
// rsp has an output register; the next word is taken once it is free.
// ----------------------------------------------------------------------------
module symmetric_sparse_matvec (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // row[9:0] col[19:10] vsel[21:20] value[53:22]
   input  logic [1:0]  req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // y_value[47:0] saturated[48]
   output logic        rsp_tuser,  // status
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [10:0] csr_data
);
   import ssmv_pkg::*;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001, ST_IDLE = 7'b0000010, ST_XRD = 7'b0000100,
      ST_XWAIT = 7'b0001000, ST_MUL = 7'b0010000, ST_ACC = 7'b0100000,
      ST_RESP = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [10:0] dim_ff;
   logic [2:0]  nv_ff;
   logic [AddrW:0] clr_ff, clr_in;
   logic [1:0] rq_ff;
   logic [RowW-1:0] row_ff, col_ff;
   logic [VecW-1:0] vsel_ff, vec_ff, vec_in;
   logic signed [XW-1:0] val_ff;
   logic side_ff, side_in;   // 0 y[row] += v*x[col], 1 y[col] += v*x[row]
   logic signed [XW-1:0] xop_ff, xop_in;
   logic rsp_valid_ff, status_ff, sat_ff;
   logic signed [AccW-1:0] yv_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= '0;
         nv_ff <= 3'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIMENSION: dim_ff <= csr_data;
            CSR_NUM_VECTORS: nv_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   logic [10:0] dim_eff;
   logic [4:0] nv_eff;
   assign dim_eff = (dim_ff > 11'(MaxDim)) ? 11'(MaxDim) : dim_ff;
   assign nv_eff = (nv_ff == 0) ? 5'd1 :
                   ((5'(nv_ff) > 5'(Vectors)) ? 5'(Vectors) : 5'(nv_ff));

   // decode of incoming word
   logic [RowW-1:0] in_row, in_col;
   logic [1:0] in_vsel;
   assign in_row = req_tdata[9:0];
   assign in_col = req_tdata[19:10];
   assign in_vsel = req_tdata[21:20];
   logic in_ok;
   always_comb begin
      in_ok = 1'b0;
      case (req_tuser)
         REQ_LOAD, REQ_READ:
            in_ok = (11'(in_row) < dim_eff) && (3'(in_vsel) < 3'(Vectors));
         REQ_ENTRY: in_ok = (11'(in_row) < dim_eff) && (11'(in_col) < dim_eff);
         default: in_ok = 1'b0;
      endcase
   end

   logic accept;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign accept = req_tvalid && req_tready;

   // memories
   logic x_we, y_we;
   logic [AddrW-1:0] x_addr, y_addr;
   logic [XW-1:0] x_rd;
   logic [YW-1:0] y_wd, y_rd;
   ssmv_ram #(.Width(XW), .Depth(Depth)) u_x (
      .clock(clock), .we(x_we), .addr(x_addr), .wdata(val_ff), .rdata(x_rd));
   ssmv_ram #(.Width(YW), .Depth(Depth)) u_y (
      .clock(clock), .we(y_we), .addr(y_addr), .wdata(y_wd), .rdata(y_rd));

   logic signed [AccW:0] prod;
   ssmv_mac u_mac (.clock(clock), .a(val_ff), .b(xop_ff), .prod_rnd(prod));

   // saturating sum
   logic signed [AccW+1:0] sum;
   logic signed [AccW-1:0] acc_new;
   logic sat_new;
   assign sum = {{2{y_rd[AccW-1]}}, y_rd[AccW-1:0]} + {prod[AccW], prod};
   always_comb begin
      if (sum > (AccW+2)'(AccMax)) begin
         acc_new = AccMax; sat_new = 1'b1;
      end else if (sum < (AccW+2)'(AccMin)) begin
         acc_new = AccMin; sat_new = 1'b1;
      end else begin
         acc_new = sum[AccW-1:0]; sat_new = y_rd[AccW];
      end
   end

   logic [RowW-1:0] tgt, src;
   assign tgt = side_ff ? col_ff : row_ff;
   assign src = side_ff ? row_ff : col_ff;
   logic is_read;
   assign is_read = (rq_ff == REQ_READ);

   // sequencer
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      vec_in = vec_ff;
      side_in = side_ff;
      xop_in = xop_ff;
      x_we = 1'b0;
      y_we = 1'b0;
      x_addr = {vec_ff, src};
      y_addr = {vec_ff, tgt};
      y_wd = {sat_new, acc_new};
      case (state_ff)
         ST_CLEAR: begin
            y_we = 1'b1;
            y_addr = clr_ff[AddrW-1:0];
            y_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AddrW+1)'(Depth - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            vec_in = '0;
            side_in = 1'b0;
            if (accept) state_in = in_ok ? ST_XRD : ST_RESP;
         end
         ST_XRD: begin
            // load: write x; read: fetch y; entry: fetch x operand and y target
            if (rq_ff == REQ_LOAD) begin
               x_we = 1'b1;
               x_addr = {vsel_ff, row_ff};
               state_in = ST_RESP;
            end else if (is_read) begin
               y_addr = {vsel_ff, row_ff};
               state_in = ST_XWAIT;
            end else begin
               state_in = ST_XWAIT;
            end
         end
         ST_XWAIT: begin
            if (is_read) begin
               y_we = 1'b1;
               y_addr = {vsel_ff, row_ff};
               y_wd = '0;
               state_in = ST_RESP;
            end else begin
               xop_in = x_rd;
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_ACC;   // product register, y read under way
         ST_ACC: begin
            y_we = 1'b1;
            if (!side_ff && (row_ff != col_ff)) begin
               side_in = 1'b1;
               state_in = ST_XRD;
            end else if (5'(vec_ff) + 5'd1 < nv_eff) begin
               side_in = 1'b0;
               vec_in = vec_ff + 1'b1;
               state_in = ST_XRD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end
   // y read for ST_MUL comes from y_addr default during MUL (registered at ACC)

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
      end
      vec_ff <= vec_in;
      side_ff <= side_in;
      xop_ff <= xop_in;
   end

   // captured word
   logic [1:0] y_sel;
   always_ff @(posedge clock) begin
      if (accept) begin
         rq_ff <= req_tuser;
         row_ff <= in_row;
         col_ff <= in_col;
         vsel_ff <= in_vsel[VecW-1:0];
         val_ff <= req_tdata[53:22];
         status_ff <= !in_ok;
      end
   end
   assign y_sel = rq_ff;

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_RESP) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_XWAIT && y_sel == REQ_READ) begin
         yv_ff <= y_rd[AccW-1:0];
         sat_ff <= y_rd[AccW];
      end else if (state_ff == ST_XRD) begin
         yv_ff <= '0;
         sat_ff <= 1'b0;
      end else if (state_ff == ST_IDLE && accept && !in_ok) begin
         yv_ff <= '0;
         sat_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = status_ff;
   assign rsp_tdata = {7'd0, sat_ff, yv_ff};
endmodule

>>> rtl/ssmv_checker.sv
// ----------------------------------------------------------------------------
// ssmv_checker
// port level checks of the symmetric sparse matvec block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ssmv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser
);
   // no new word while a response waits
   `ASSERT_NEVER(a_no_take, clock, reset, rsp_tvalid && req_tready, "req taken, rsp pending")
   // an accepted word keeps the block busy on the next cycle
   `ASSERT_IMP(a_busy, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "ready after accept")
   // ignored words report zero data
   `ASSERT_IMP(a_zero, clock, reset, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 56'd0), "data on ignore")
   // stalled response holds
   `ASSERT_IMP(a_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)), "rsp moved")
endmodule

bind symmetric_sparse_matvec ssmv_checker u_ssmv_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser));

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stream test of the symmetric sparse matvec block: loads, entries and reads
// are checked word by word against a predictor of the x and y stores
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import ssmv_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int CycleLimit = 600000;
   localparam int DrainCycles = 40;
   localparam int IndexSpan = 16;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;  // row[9:0] col[19:10] vsel[21:20] value[53:22]
   logic [1:0]  req_tuser;  // req_type
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;  // y_value[47:0] saturated[48]
   logic        rsp_tuser;  // status
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [10:0] csr_data;

   symmetric_sparse_matvec uut (.*);

   // predictor state and configuration
   logic signed [31:0] x_mem [Depth];
   bit                 x_loaded [Depth];
   logic signed [47:0] y_acc [Depth];
   bit                 y_sat [Depth];
   int                 cur_dim;
   int                 cur_nv;

   rsp_type expected_words [$];
   int      mismatches;
   int      cycles;
   bit      idling_on;

   always #5 clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // rsp stalls in random bursts
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // compare each rsp word with the oldest expectation
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser;
         got.y_value = rsp_tdata[47:0];
         got.saturated = rsp_tdata[48];
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp word: status %0d y %h sat %0d",
                        got.status, got.y_value, got.saturated);
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp mismatch: expected status %0d y %h sat %0d, got %0d %h %0d",
                           want.status, want.y_value, want.saturated,
                           got.status, got.y_value, got.saturated);
            end
         end
      end
   end

   // q16.16 product rounded half up to q32.16, added with saturation
   function automatic void accumulate(int idx, logic signed [31:0] a,
                                      logic signed [31:0] b);
      longint t;
      longint s;
      t = (longint'(a) * longint'(b) + 64'sd32768) >>> 16;
      s = longint'(y_acc[idx]) + t;
      if (s > longint'(AccMax)) begin
         s = AccMax;
         y_sat[idx] = 1'b1;
      end else if (s < longint'(AccMin)) begin
         s = AccMin;
         y_sat[idx] = 1'b1;
      end
      y_acc[idx] = s[47:0];
   endfunction

   function automatic rsp_type predict_word(logic [1:0] kind, int row, int col, int vsel,
                                            logic signed [31:0] value);
      rsp_type r;
      int idx;
      r = '0;
      r.status = 1'b1;
      idx = vsel * MaxDim + row;
      if ((kind == REQ_LOAD || kind == REQ_READ) && row < cur_dim && vsel < Vectors) begin
         r.status = 1'b0;
         if (kind == REQ_LOAD) begin
            x_mem[idx] = value;
            x_loaded[idx] = 1'b1;
         end else begin
            r.y_value = y_acc[idx];
            r.saturated = y_sat[idx];
            y_acc[idx] = '0;
            y_sat[idx] = 1'b0;
         end
      end else if (kind == REQ_ENTRY && row < cur_dim && col < cur_dim) begin
         r.status = 1'b0;
         for (int v = 0; v < cur_nv; v++) begin
            accumulate(v * MaxDim + row, value, x_mem[v * MaxDim + col]);
            if (row != col)
               accumulate(v * MaxDim + col, value, x_mem[v * MaxDim + row]);
         end
      end
      return r;
   endfunction

   // send one req word; valid stays high into the next word unless a gap follows
   task automatic send_word(logic [1:0] kind, int row, int col, int vsel,
                            logic signed [31:0] value);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, value, vsel[1:0], col[9:0], row[9:0]};
      do @(posedge clock); while (!req_tready);
      expected_words.push_back(predict_word(kind, row, col, vsel, value));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // write enable is left high; the caller drops it after the last write
   task automatic write_csr(logic [0:0] index, int data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= data[10:0];
      @(posedge clock);
      if (index == CSR_DIMENSION)
         cur_dim = (data > MaxDim) ? MaxDim : data;
      else
         cur_nv = (data == 0) ? 1 : ((data > Vectors) ? Vectors : data);
   endtask

   task automatic configure(int dim, int nv);
      drain();
      write_csr(CSR_DIMENSION, dim);
      write_csr(CSR_NUM_VECTORS, nv);
      csr_we <= 1'b0;
   endtask

   // an in-range entry must only touch x elements that were loaded
   task automatic send_entry(int row, int col, logic signed [31:0] value);
      if (row < cur_dim && col < cur_dim)
         for (int v = 0; v < cur_nv; v++) begin
            if (!x_loaded[v * MaxDim + row])
               send_word(REQ_LOAD, row, $urandom_range(0, 1023), v, $urandom);
            if (!x_loaded[v * MaxDim + col])
               send_word(REQ_LOAD, col, $urandom_range(0, 1023), v, $urandom);
         end
      send_word(REQ_ENTRY, row, col, $urandom_range(0, 3), value);
   endtask

   task automatic test_directed();
      configure(0, 0);
      send_word(REQ_LOAD, 0, 0, 0, 32'sd1);
      send_word(REQ_READ, 0, 0, 0, 0);
      send_word(REQ_ENTRY, 0, 0, 0, 32'sd1);
      configure(4, 4);
      for (int v = 0; v < 4; v++)
         for (int i = 0; i < 2; i++)
            send_word(REQ_LOAD, i + 2 * (v % 2), 0, v, 32'sd65536 * (v + 1));
      send_entry(3, 1, 32'sh0001_8000);   // column below row
      send_entry(1, 3, -32'sd98304);      // column above row
      send_entry(2, 2, 32'sd65536);       // diagonal
      send_word(REQ_ENTRY, 4, 0, 0, 32'sd1);  // row out of range
      send_word(REQ_ENTRY, 0, 4, 0, 32'sd1);  // column out of range
      send_word(REQ_LOAD, 1023, 1023, 3, 32'sd5);
      send_word(REQ_UNUSED, 0, 0, 0, 32'sd7);
      for (int v = 0; v < 4; v++)
         send_word(REQ_READ, 1, 0, v, 0);
      send_word(REQ_READ, 3, 0, 0, 0);
      send_word(REQ_READ, 3, 0, 0, 0);    // cleared by the previous read
   endtask

   task automatic test_saturation();
      configure(2, 2);
      send_word(REQ_LOAD, 0, 0, 0, 32'sh7fff_ffff);
      send_word(REQ_LOAD, 1, 0, 0, 32'sh8000_0000);
      send_word(REQ_LOAD, 0, 0, 1, 32'sh8000_0000);
      send_word(REQ_LOAD, 1, 0, 1, 32'sh8000_0000);
      repeat (6) send_entry(1, 0, 32'sh7fff_ffff);
      repeat (6) send_entry(1, 1, 32'sh8000_0000);
      for (int v = 0; v < 2; v++) begin
         send_word(REQ_READ, 0, 0, v, 0);
         send_word(REQ_READ, 1, 0, v, 0);
      end
   endtask

   // mostly a small window of rows so that entries find x already loaded
   function automatic int pick_index();
      int span;
      span = (cur_dim < IndexSpan) ? cur_dim : IndexSpan;
      if (span > 0 && $urandom_range(0, 9) != 0)
         return $urandom_range(0, span - 1);
      return $urandom_range(0, 1023);
   endfunction

   task automatic test_random(int dim, int nv, int words);
      int pick;
      configure(dim, nv);
      for (int n = 0; n < words; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 22)
            send_word(REQ_LOAD, pick_index(), $urandom_range(0, 1023),
                      $urandom_range(0, 3), $urandom);
         else if (pick < 72)
            send_entry(pick_index(), pick_index(),
                       (pick < 30) ? $signed(32'($urandom)) :
                       $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000);
         else if (pick < 97)
            send_word(REQ_READ, pick_index(), $urandom_range(0, 1023),
                      $urandom_range(0, 3), $urandom);
         else
            send_word(REQ_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 3), $urandom);
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      rsp_tready = 1'b1;
      cycles = 0;
      mismatches = 0;
      idling_on = 1'b1;
      cur_dim = 0;
      cur_nv = 1;
      for (int i = 0; i < Depth; i++) begin
         x_mem[i] = '0;
         x_loaded[i] = 1'b0;
         y_acc[i] = '0;
         y_sat[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_saturation();
      test_random(5, 1, 130);
      test_random(1, 7, 60);
      test_random(37, 3, 120);
      test_random(1024, 4, 100);
      test_random(2047, 2, 90);
      test_random(12, 4, 120);
      test_random(1023, 5, 100);
      test_random(8, 0, 110);
      idling_on = 1'b0;
      test_random(20, 4, 100);
      drain();

      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> symmetric_sparse_matvec.f
+incdir+rtl
rtl/ssmv_pkg.sv
rtl/ssmv_ram.sv
rtl/ssmv_mac.sv
rtl/symmetric_sparse_matvec.sv
rtl/ssmv_checker.sv
test/tb_top.sv
